[hdl/shs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics histogram package
// Shared widths, constants and the types that pass between the front end
// and the back end.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int MAX_SAMPLES   = 4096;
  localparam int ADDR_BITS     = $clog2(MAX_SAMPLES);
  localparam int CNT_BITS      = ADDR_BITS + 1;
  localparam int SUM_BITS      = SAMPLE_BITS + CNT_BITS;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS + CNT_BITS;
  localparam int BIN_LIMIT     = 64;
  localparam int BIN_BITS      = $clog2(BIN_LIMIT);
  localparam int NB_BITS       = BIN_BITS + 1;
  localparam int WIDE_BITS     = 72;
  localparam int ROOT_BITS     = WIDE_BITS / 2;
  localparam int DIVISOR_BITS  = SAMPLE_BITS;
  localparam int ITER_BITS     = 7;
  localparam int BIN_PROD_BITS = SAMPLE_BITS + NB_BITS;
  localparam int SPLIT_BITS    = 18;

  // Iteration counts of the shared divider for each kind of quotient.
  localparam logic [ITER_BITS-1:0] DIV_MEAN_ITERS = ITER_BITS'(SUM_BITS);
  localparam logic [ITER_BITS-1:0] DIV_ROOT_ITERS = ITER_BITS'(ROOT_BITS);
  localparam logic [ITER_BITS-1:0] DIV_WIDE_ITERS = ITER_BITS'(WIDE_BITS);
  localparam logic [ITER_BITS-1:0] DIV_BIN_ITERS  = ITER_BITS'(BIN_PROD_BITS);

  // Summary of one finished set, handed from the front end to the back end.
  typedef struct packed {
    logic [CNT_BITS-1:0]           n;
    logic signed [SAMPLE_BITS-1:0] min;
    logic signed [SAMPLE_BITS-1:0] max;
    logic signed [SUM_BITS-1:0]    sum;
    logic [SQ_BITS-1:0]            sq;
    logic                          dropped;
  } job_t;

  // Read request into the sample store.
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } st_rd_t;

endpackage
`default_nettype wire

[hdl/shs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics front end
// Takes in sample words, stores enabled samples and keeps the running
// minimum, maximum, sum and sum of squares; hands a set summary to the back
// end through a one-entry job slot.
// ----------------------------------------------------------------------------
module shs_front import shs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          sample_enabled,
  input  logic                          end_of_set,
  output job_t                          job,
  output logic                          job_valid,
  input  logic                          job_pop,
  input  logic                          release_store,
  output logic                          store_busy,
  input  st_rd_t                        rd,
  output logic [SAMPLE_BITS-1:0]        rd_data
);

  logic [CNT_BITS-1:0]           count;
  logic signed [SAMPLE_BITS-1:0] rmin;
  logic signed [SAMPLE_BITS-1:0] rmax;
  logic signed [SUM_BITS-1:0]    rsum;
  logic [SQ_BITS-1:0]            rsq;
  logic                          drop;
  logic                          sq_valid;
  logic [2*SAMPLE_BITS-1:0]      sq_prod;
  logic                          eos_b;
  logic [SAMPLE_BITS-1:0]        store [MAX_SAMPLES];

  logic                   accept;
  logic                   has_room;
  logic                   take;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_BITS-1:0]     sq_final;

  assign full     = store_busy || eos_b;
  assign accept   = push && !full;
  assign has_room = count < CNT_BITS'(MAX_SAMPLES);
  assign take     = accept && sample_enabled && has_room;
  assign mag      = sample_value[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_value)
                                                : SAMPLE_BITS'(sample_value);
  assign sq_final = rsq + (sq_valid ? SQ_BITS'(sq_prod) : '0);

  // The square is registered and added in the next cycle.
  always_ff @(posedge clk) begin
    sq_prod <= (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rmin       <= '0;
      rmax       <= '0;
      rsum       <= '0;
      rsq        <= '0;
      drop       <= 1'b0;
      sq_valid   <= 1'b0;
      eos_b      <= 1'b0;
      store_busy <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      sq_valid <= take;
      eos_b    <= accept && end_of_set;
      if (take) begin
        count <= count + 1'b1;
        rsum  <= rsum + SUM_BITS'(sample_value);
        if (count == '0 || sample_value < rmin) begin
          rmin <= sample_value;
        end
        if (count == '0 || sample_value > rmax) begin
          rmax <= sample_value;
        end
      end
      if (accept && sample_enabled && !has_room) begin
        drop <= 1'b1;
      end
      if (sq_valid) begin
        rsq <= sq_final;
      end
      if (job_pop) begin
        job_valid <= 1'b0;
      end
      if (release_store) begin
        store_busy <= 1'b0;
      end
      // The set closes in the cycle after its last word, once its square is in.
      if (eos_b) begin
        if (count != '0) begin
          job_valid  <= 1'b1;
          store_busy <= 1'b1;
        end
        count <= '0;
        rmin  <= '0;
        rmax  <= '0;
        rsum  <= '0;
        rsq   <= '0;
        drop  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eos_b) begin
      job <= '{n: count, min: rmin, max: rmax, sum: rsum, sq: sq_final, dropped: drop};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      store[count[ADDR_BITS-1:0]] <= sample_value;
    end
    if (rd.en) begin
      rd_data <= store[rd.addr];
    end
  end

endmodule
`default_nettype wire

[hdl/shs_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics divider
// Restoring divider, one quotient bit per cycle; the caller gives how many
// dividend bits are significant.
// ----------------------------------------------------------------------------
module shs_div import shs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDE_BITS-1:0]    dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  input  logic [ITER_BITS-1:0]    nbits,
  output logic                    done,
  output logic [WIDE_BITS-1:0]    quotient
);

  logic                    busy;
  logic [ITER_BITS-1:0]    cnt;
  logic [WIDE_BITS-1:0]    q;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS:0]   rem_sh;
  logic                    ge;
  logic [DIVISOR_BITS:0]   rem_nx;

  assign rem_sh   = {rem, q[WIDE_BITS-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_nx   = ge ? rem_sh - {1'b0, divisor} : rem_sh;
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend << (ITER_BITS'(WIDE_BITS) - nbits);
      rem <= '0;
      cnt <= nbits;
    end else if (busy) begin
      q   <= {q[WIDE_BITS-2:0], ge};
      rem <= rem_nx[DIVISOR_BITS-1:0];
      cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/shs_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module shs_sqrt import shs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WIDE_BITS-1:0] x,
  output logic                 done,
  output logic [ROOT_BITS-1:0] root
);

  logic                 busy;
  logic [ITER_BITS-1:0] cnt;
  logic [WIDE_BITS-1:0] xs;
  logic [ROOT_BITS+1:0] rem;
  logic [ROOT_BITS+3:0] rem_sh;
  logic [ROOT_BITS+3:0] trial;
  logic                 ge;
  logic [ROOT_BITS+3:0] rem_nx;

  assign rem_sh = {rem, xs[WIDE_BITS-1 -: 2]};
  assign trial  = (ROOT_BITS+4)'({root, 2'b01});
  assign ge     = rem_sh >= trial;
  assign rem_nx = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
      cnt  <= ITER_BITS'(ROOT_BITS);
    end else if (busy) begin
      xs   <= {xs[WIDE_BITS-3:0], 2'b00};
      rem  <= rem_nx[ROOT_BITS+1:0];
      root <= {root[ROOT_BITS-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/shs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics back end
// Works out mean, deviation and error of a finished set, bins its stored
// samples and sends one result word per bin through an output register.
// ----------------------------------------------------------------------------
module shs_back import shs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  job_t                          job,
  input  logic                          job_valid,
  output logic                          job_pop,
  output logic                          release_store,
  output st_rd_t                        rd,
  input  logic [SAMPLE_BITS-1:0]        rd_data,
  output logic                          empty,
  input  logic                          pop,
  output logic [BIN_BITS-1:0]           bin_index,
  output logic signed [SAMPLE_BITS-1:0] bin_position,
  output logic [CNT_BITS-1:0]           bin_count,
  output logic signed [SAMPLE_BITS-1:0] min_value,
  output logic signed [SAMPLE_BITS-1:0] max_value,
  output logic signed [SAMPLE_BITS-1:0] mean_value,
  output logic [SAMPLE_BITS-1:0]        std_dev,
  output logic [SAMPLE_BITS-1:0]        std_err,
  output logic [CNT_BITS-1:0]           sample_count,
  output logic                          overflow,
  output logic                          last_bin
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_MUL  = 17'h00002,
    S_MEAN = 17'h00004,
    S_SQX  = 17'h00008,
    S_STD  = 17'h00010,
    S_E1   = 17'h00020,
    S_E2   = 17'h00040,
    S_E3   = 17'h00080,
    S_SQE  = 17'h00100,
    S_NB   = 17'h00200,
    S_CLR  = 17'h00400,
    S_BRD  = 17'h00800,
    S_BDIV = 17'h01000,
    S_BCNT = 17'h02000,
    S_BUPD = 17'h04000,
    S_EPOS = 17'h08000,
    S_EOUT = 17'h10000
  } state_t;

  state_t               state;
  job_t                 jb;
  logic [SUM_BITS-1:0]  asum;
  logic                 sneg;
  logic [WIDE_BITS-1:0] acc;
  logic [WIDE_BITS-1:0] prod;
  logic                 psub;
  logic [2:0]           mstep;
  logic                 op_busy;
  logic [WIDE_BITS-1:0] q;
  logic [ROOT_BITS-1:0] rx;
  logic [NB_BITS-1:0]   nbins;
  logic [SAMPLE_BITS-1:0] range;
  logic [CNT_BITS-1:0]  i;
  logic [NB_BITS-1:0]   j;
  logic [BIN_BITS-1:0]  bidx;
  logic [SAMPLE_BITS-1:0] step;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0] stdv;
  logic [SAMPLE_BITS-1:0] ste;
  logic                 out_valid;

  logic [CNT_BITS-1:0]  cnt_mem [BIN_LIMIT];
  logic [CNT_BITS-1:0]  cnt_rdata;
  logic                 cnt_we;
  logic [BIN_BITS-1:0]  cnt_waddr;
  logic [CNT_BITS-1:0]  cnt_wdata;
  logic                 cnt_re;
  logic [BIN_BITS-1:0]  cnt_raddr;

  logic                    div_start;
  logic [WIDE_BITS-1:0]    div_dividend;
  logic [DIVISOR_BITS-1:0] div_divisor;
  logic [ITER_BITS-1:0]    div_nbits;
  logic                    div_done;
  logic [WIDE_BITS-1:0]    div_quo;
  logic                    sq_start;
  logic [WIDE_BITS-1:0]    sq_x;
  logic                    sq_done;
  logic [ROOT_BITS-1:0]    sq_root;

  logic [SAMPLE_BITS-1:0]   off;
  logic [SPLIT_BITS-1:0]    al;
  logic [SUM_BITS-SPLIT_BITS-1:0] ah;
  logic [WIDE_BITS-1:0]     mul_op;
  logic                     bin_skip;
  logic                     pos_skip;
  logic                     set_done;
  logic                     out_load;

  assign off      = rd_data - jb.min;
  assign al       = asum[SPLIT_BITS-1:0];
  assign ah       = asum[SUM_BITS-1:SPLIT_BITS];
  assign bin_skip = range == '0;
  assign pos_skip = nbins == NB_BITS'(1);
  assign set_done = (i + 1'b1) == jb.n;
  assign out_load = !out_valid || pop;
  assign empty    = !out_valid;

  // Partial products of n * S2 - S1 * S1, one per cycle.
  always_comb begin
    case (mstep)
      3'd0:    mul_op = WIDE_BITS'(jb.sq[31:0]) * WIDE_BITS'(jb.n);
      3'd1:    mul_op = (WIDE_BITS'(jb.sq[SQ_BITS-1:32]) * WIDE_BITS'(jb.n)) << 32;
      3'd2:    mul_op = WIDE_BITS'(al) * WIDE_BITS'(al);
      3'd3:    mul_op = (WIDE_BITS'(ah) * WIDE_BITS'(al)) << (SPLIT_BITS + 1);
      3'd4:    mul_op = (WIDE_BITS'(ah) * WIDE_BITS'(ah)) << (2 * SPLIT_BITS);
      default: mul_op = '0;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DIVISOR_BITS'(jb.n);
    div_nbits    = DIV_WIDE_ITERS;
    sq_start     = 1'b0;
    sq_x         = acc;
    case (state)
      S_MEAN: begin
        div_start    = !op_busy;
        div_dividend = WIDE_BITS'(asum);
        div_nbits    = DIV_MEAN_ITERS;
      end
      S_STD: begin
        div_start    = !op_busy;
        div_dividend = WIDE_BITS'(rx);
        div_nbits    = DIV_ROOT_ITERS;
      end
      S_E1: begin
        div_start    = !op_busy;
        div_dividend = acc;
      end
      S_E2, S_E3: begin
        div_start    = !op_busy;
        div_dividend = q;
      end
      S_BDIV: begin
        div_start    = !op_busy && !bin_skip;
        div_dividend = WIDE_BITS'(BIN_PROD_BITS'(nbins - 1'b1) * BIN_PROD_BITS'(off));
        div_divisor  = range;
        div_nbits    = DIV_BIN_ITERS;
      end
      S_EPOS: begin
        div_start    = !op_busy && !pos_skip;
        div_dividend = WIDE_BITS'(BIN_PROD_BITS'(j) * BIN_PROD_BITS'(range));
        div_divisor  = DIVISOR_BITS'(nbins - 1'b1);
        div_nbits    = DIV_BIN_ITERS;
      end
      S_SQX: begin
        sq_start = !op_busy;
      end
      S_SQE: begin
        sq_start = !op_busy;
        sq_x     = q;
      end
      S_NB: begin
        sq_start = !op_busy;
        sq_x     = WIDE_BITS'(jb.n);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job_pop       = state == S_IDLE && job_valid;
    release_store = state == S_BUPD && set_done;
    rd.en         = state == S_BRD;
    rd.addr       = i[ADDR_BITS-1:0];
    cnt_re        = state == S_BCNT || state == S_EPOS;
    cnt_raddr     = state == S_BCNT ? bidx : j[BIN_BITS-1:0];
    cnt_we        = state == S_CLR || state == S_BUPD;
    cnt_waddr     = state == S_CLR ? j[BIN_BITS-1:0] : bidx;
    cnt_wdata     = state == S_CLR ? '0 : cnt_rdata + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_busy   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (div_start || sq_start) begin
        op_busy <= 1'b1;
      end
      if (div_done || sq_done) begin
        op_busy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mstep == 3'd5) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: if (div_done) state <= S_SQX;
        S_SQX:  if (sq_done)  state <= S_STD;
        S_STD:  if (div_done) state <= S_E1;
        S_E1:   if (div_done) state <= S_E2;
        S_E2:   if (div_done) state <= S_E3;
        S_E3:   if (div_done) state <= S_SQE;
        S_SQE:  if (sq_done)  state <= S_NB;
        S_NB:   if (sq_done)  state <= S_CLR;
        S_CLR: begin
          if (j == NB_BITS'(BIN_LIMIT - 1)) begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          state <= S_BDIV;
        end
        S_BDIV: begin
          if (bin_skip || div_done) begin
            state <= S_BCNT;
          end
        end
        S_BCNT: begin
          state <= S_BUPD;
        end
        S_BUPD: begin
          state <= set_done ? S_EPOS : S_BRD;
        end
        S_EPOS: begin
          if (pos_skip || div_done) begin
            state <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= ((j + 1'b1) == nbins) ? S_IDLE : S_EPOS;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        jb    <= job;
        sneg  <= job.sum[SUM_BITS-1];
        asum  <= job.sum[SUM_BITS-1] ? SUM_BITS'(-job.sum) : SUM_BITS'(job.sum);
        acc   <= '0;
        mstep <= '0;
      end
      S_MUL: begin
        prod  <= mul_op;
        psub  <= mstep >= 3'd2;
        mstep <= mstep + 1'b1;
        if (mstep != 3'd0) begin
          acc <= psub ? acc - prod : acc + prod;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          mean <= sneg ? SAMPLE_BITS'(-div_quo[SAMPLE_BITS-1:0])
                       : div_quo[SAMPLE_BITS-1:0];
        end
      end
      S_SQX: if (sq_done) rx <= sq_root;
      S_STD: if (div_done) stdv <= div_quo[SAMPLE_BITS-1:0];
      S_E1, S_E2, S_E3: begin
        if (div_done) begin
          q <= div_quo;
        end
      end
      S_SQE: if (sq_done) ste <= sq_root[SAMPLE_BITS-1:0];
      S_NB: begin
        if (sq_done) begin
          nbins <= (sq_root > ROOT_BITS'(BIN_LIMIT)) ? NB_BITS'(BIN_LIMIT)
                                                     : sq_root[NB_BITS-1:0];
          range <= jb.max - jb.min;
          j     <= '0;
        end
      end
      S_CLR: begin
        j <= j + 1'b1;
        i <= '0;
      end
      S_BDIV: begin
        if (bin_skip) begin
          bidx <= '0;
        end else if (div_done) begin
          bidx <= div_quo[BIN_BITS-1:0];
        end
      end
      S_BUPD: begin
        i <= i + 1'b1;
        j <= '0;
      end
      S_EPOS: begin
        if (pos_skip) begin
          step <= '0;
        end else if (div_done) begin
          step <= div_quo[SAMPLE_BITS-1:0];
        end
      end
      S_EOUT: begin
        if (out_load) begin
          bin_index    <= j[BIN_BITS-1:0];
          bin_position <= jb.min + step;
          bin_count    <= cnt_rdata;
          min_value    <= jb.min;
          max_value    <= jb.max;
          mean_value   <= mean;
          std_dev      <= stdv;
          std_err      <= ste;
          sample_count <= jb.n;
          overflow     <= jb.dropped;
          last_bin     <= (j + 1'b1) == nbins;
          j            <= j + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  shs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .done     (div_done),
    .quotient (div_quo)
  );

  shs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

endmodule
`default_nettype wire

[hdl/sample_stats_histogram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics histogram
// Collects a set of fixed-point samples and reports its statistics together
// with a square-root-sized histogram, one result word per bin.
// ----------------------------------------------------------------------------
// Sample words are taken one per clock while a set loads and full is low.
// When a word marked end_of_set is taken, full goes high while the set is
// closed and stays high until the back end has read the sample store: fixed
// work (a multiply, three square roots, five divisions, a sweep clearing the
// bin counters) and then one division per stored sample (skipped when all
// samples are equal), all divisions on the one shared bit-serial divider.
// Once binning is done the next set may load while the bins are sent, each
// after its position is worked out plus any wait on pop. A set with no
// enabled samples gives no results. Enabled samples past 4096 are dropped
// and flagged by overflow on every result word of the set.
module sample_stats_histogram import shs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          sample_enabled,
  input  logic                          end_of_set,
  output logic                          empty,
  input  logic                          pop,
  output logic [BIN_BITS-1:0]           bin_index,
  output logic signed [SAMPLE_BITS-1:0] bin_position,
  output logic [CNT_BITS-1:0]           bin_count,
  output logic signed [SAMPLE_BITS-1:0] min_value,
  output logic signed [SAMPLE_BITS-1:0] max_value,
  output logic signed [SAMPLE_BITS-1:0] mean_value,
  output logic [SAMPLE_BITS-1:0]        std_dev,
  output logic [SAMPLE_BITS-1:0]        std_err,
  output logic [CNT_BITS-1:0]           sample_count,
  output logic                          overflow,
  output logic                          last_bin
);

  job_t                   job;
  logic                   job_valid;
  logic                   job_pop;
  logic                   release_store;
  logic                   store_busy;
  st_rd_t                 rd;
  logic [SAMPLE_BITS-1:0] rd_data;

  // The front end owns the sample store and the running sums.
  shs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .sample_value   (sample_value),
    .sample_enabled (sample_enabled),
    .end_of_set     (end_of_set),
    .job            (job),
    .job_valid      (job_valid),
    .job_pop        (job_pop),
    .release_store  (release_store),
    .store_busy     (store_busy),
    .rd             (rd),
    .rd_data        (rd_data)
  );

  // The back end finishes the statistics and produces the bins.
  shs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .job_valid     (job_valid),
    .job_pop       (job_pop),
    .release_store (release_store),
    .rd            (rd),
    .rd_data       (rd_data),
    .empty         (empty),
    .pop           (pop),
    .bin_index     (bin_index),
    .bin_position  (bin_position),
    .bin_count     (bin_count),
    .min_value     (min_value),
    .max_value     (max_value),
    .mean_value    (mean_value),
    .std_dev       (std_dev),
    .std_err       (std_err),
    .sample_count  (sample_count),
    .overflow      (overflow),
    .last_bin      (last_bin)
  );

`ifndef SYNTHESIS
  // The back end only takes a job that is waiting in the slot.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("job taken from an empty slot");
  // A waiting job always holds the sample store.
  a_job_busy: assert property (@(posedge clk) disable iff (rst) job_valid |-> store_busy)
    else $error("job waiting while the store is free");
  // The store is handed back only by a job already taken from the slot.
  a_release: assert property (@(posedge clk) disable iff (rst)
    release_store |-> store_busy && !job_valid)
    else $error("store released out of turn");
`endif

endmodule
`default_nettype wire
